FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is low
`define HDU_ASSERT_CR(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// same, on the usual clk / rst_n pair
`define HDU_ASSERT(lbl, prop, msg) `HDU_ASSERT_CR(lbl, clk, rst_n, prop, msg)

`endif

FILE: hdl/hdu_pkg.sv
// Types and constants of the half-duplex serial port
`timescale 1ns / 1ps
`default_nettype none

package hdu_pkg;

  localparam int unsigned BitPeriodW   = 16;
  localparam logic [BitPeriodW-1:0] BitPeriodReset = 16'd100;
  localparam int unsigned InTdataW     = 16;
  localparam int unsigned OutTdataW    = 16;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_TX_START  = 5'd1,
    PH_TX_D0     = 5'd2,
    PH_TX_D1     = 5'd3,
    PH_TX_D2     = 5'd4,
    PH_TX_D3     = 5'd5,
    PH_TX_D4     = 5'd6,
    PH_TX_D5     = 5'd7,
    PH_TX_D6     = 5'd8,
    PH_TX_D7     = 5'd9,
    PH_TX_STOP   = 5'd10,
    PH_TX_FINISH = 5'd11,
    PH_RX_START  = 5'd12,
    PH_RX_D0     = 5'd13,
    PH_RX_D1     = 5'd14,
    PH_RX_D2     = 5'd15,
    PH_RX_D3     = 5'd16,
    PH_RX_D4     = 5'd17,
    PH_RX_D5     = 5'd18,
    PH_RX_D6     = 5'd19,
    PH_RX_D7     = 5'd20,
    PH_RX_STOP   = 5'd21,
    PH_RX_FINISH = 5'd22
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [7:0]            shift_byte;
    logic [BitPeriodW-1:0] countdown;
    logic                  prev_line;
    logic                  out_level;
    logic                  driving;
  } hdu_state_t;

  typedef struct packed {
    logic       line_out;
    logic       drive_enable;
    logic       send_accepted;
    logic       busy_res;
    logic       recv_valid;
    logic [7:0] recv_data;
    logic       start_error;
    logic       stop_error;
  } hdu_result_t;

endpackage

`default_nettype wire

FILE: hdl/half_duplex_uart_port.sv
// Output: the result of each input beat is registered into the output register when the beat is taken.
// Throughput: one input beat per cycle; the output register frees in the same
// cycle it is taken, so the ports only stall when out_tready is low.
// Reset (rst_n low, synchronous): port idle, wire released, bit period 100.
// Top level of the single-wire half-duplex 8N1 serial port
`timescale 1ns / 1ps
`default_nettype none

module half_duplex_uart_port (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [hdu_pkg::BitPeriodW-1:0]      cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] line_in, [1] send_request, [9:2] send_data, [15:10] unused
  input  logic [hdu_pkg::InTdataW-1:0]        in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] line_out, [1] drive_enable, [2] send_accepted, [3] busy_res,
  // [4] recv_valid, [12:5] recv_data, [13] start_error, [14] stop_error, [15] zero
  output logic [hdu_pkg::OutTdataW-1:0]       out_tdata
);
  import hdu_pkg::*;

  `include "assert_macros.svh"

  logic [BitPeriodW-1:0] bit_period_r;
  hdu_state_t            state_r;
  hdu_state_t            state_nxt;
  hdu_result_t           result;
  logic                  out_valid_r;
  logic [OutTdataW-1:0]  out_tdata_r;
  logic [OutTdataW-1:0]  out_tdata_nxt;
  logic                  in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  hdu_core u_core (
    .state_cur    (state_r),
    .line_in      (in_tdata[0]),
    .send_request (in_tdata[1]),
    .send_data    (in_tdata[9:2]),
    .bit_period   (bit_period_r),
    .state_nxt    (state_nxt),
    .result       (result)
  );

  assign out_tdata_nxt = {1'b0, result.stop_error, result.start_error, result.recv_data,
                          result.recv_valid, result.busy_res, result.send_accepted,
                          result.drive_enable, result.line_out};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BitPeriodReset;
    end else if (cfg_wr_en) begin
      bit_period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_IDLE;
      state_r.shift_byte <= '0;
      state_r.countdown  <= '0;
      state_r.prev_line  <= 1'b1;
      state_r.out_level  <= 1'b1;
      state_r.driving    <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  `HDU_ASSERT(a_cnt_live, (state_r.phase != PH_IDLE) |-> (state_r.countdown != '0), "countdown zero while busy")
  `HDU_ASSERT(a_rx_no_drive, (state_r.phase >= PH_RX_START) |-> !state_r.driving, "driving the wire while receiving")
  `HDU_ASSERT(a_send_start, (in_fire && (state_r.phase == PH_IDLE) && in_tdata[1]) |=> (state_r.driving && (state_r.phase == PH_TX_START)), "send request not taken")
  `HDU_ASSERT(a_phase_hold, !in_fire |=> $stable(state_r.phase), "phase moved without a beat")

endmodule

`default_nettype wire

FILE: hdl/hdu_core.sv
// Per-tick next-state and result logic of the serial port
`timescale 1ns / 1ps
`default_nettype none

module hdu_core (
  input  hdu_pkg::hdu_state_t              state_cur,
  input  logic                             line_in,
  input  logic                             send_request,
  input  logic [7:0]                       send_data,
  input  logic [hdu_pkg::BitPeriodW-1:0]   bit_period,
  output hdu_pkg::hdu_state_t              state_nxt,
  output hdu_pkg::hdu_result_t             result
);
  import hdu_pkg::*;

  logic [BitPeriodW-1:0] full_dly;
  logic [BitPeriodW-1:0] half_dly;
  logic                  is_idle;
  logic                  timeout;
  logic [4:0]            tx_diff;
  logic [4:0]            rx_diff;
  logic [2:0]            tx_idx;
  logic [2:0]            rx_idx;

  assign full_dly = (bit_period == '0) ? BitPeriodW'(1) : bit_period;
  assign half_dly = ((bit_period >> 1) == '0) ? BitPeriodW'(1) : (bit_period >> 1);
  assign is_idle  = (state_cur.phase == PH_IDLE);
  assign timeout  = !is_idle && (state_cur.countdown <= BitPeriodW'(1));
  assign tx_diff  = state_cur.phase - PH_TX_D0;
  assign rx_diff  = state_cur.phase - PH_RX_D0;
  assign tx_idx   = tx_diff[2:0];
  assign rx_idx   = rx_diff[2:0];

  // next state
  always_comb begin
    state_nxt           = state_cur;
    state_nxt.prev_line = line_in;
    if (is_idle) begin
      if (send_request) begin
        state_nxt.driving    = 1'b1;
        state_nxt.out_level  = 1'b1;
        state_nxt.shift_byte = send_data;
        state_nxt.countdown  = full_dly;
        state_nxt.phase      = PH_TX_START;
      end else if (state_cur.prev_line && !line_in) begin
        state_nxt.countdown = half_dly;
        state_nxt.phase     = PH_RX_START;
      end
    end else if (!timeout) begin
      state_nxt.countdown = state_cur.countdown - BitPeriodW'(1);
    end else begin
      state_nxt.countdown = full_dly;
      case (state_cur.phase)
        PH_TX_START: begin
          state_nxt.out_level = 1'b0;
          state_nxt.phase     = PH_TX_D0;
        end
        PH_TX_D0, PH_TX_D1, PH_TX_D2, PH_TX_D3,
        PH_TX_D4, PH_TX_D5, PH_TX_D6, PH_TX_D7: begin
          state_nxt.out_level = state_cur.shift_byte[tx_idx];
          state_nxt.phase     = phase_t'(state_cur.phase + 5'd1);
        end
        PH_TX_STOP: begin
          state_nxt.out_level = 1'b1;
          state_nxt.phase     = PH_TX_FINISH;
        end
        PH_RX_START: begin
          if (line_in) begin
            state_nxt.countdown = '0;
            state_nxt.phase     = PH_IDLE;
          end else begin
            state_nxt.shift_byte = '0;
            state_nxt.phase      = PH_RX_D0;
          end
        end
        PH_RX_D0, PH_RX_D1, PH_RX_D2, PH_RX_D3,
        PH_RX_D4, PH_RX_D5, PH_RX_D6, PH_RX_D7: begin
          state_nxt.shift_byte[rx_idx] = state_cur.shift_byte[rx_idx] | line_in;
          state_nxt.phase              = phase_t'(state_cur.phase + 5'd1);
        end
        PH_RX_STOP: begin
          state_nxt.countdown = half_dly;
          state_nxt.phase     = PH_RX_FINISH;
        end
        PH_RX_FINISH: begin
          state_nxt.countdown = '0;
          state_nxt.phase     = PH_IDLE;
        end
        default: begin
          // end of transmit, or a code that means nothing
          state_nxt.driving   = 1'b0;
          state_nxt.out_level = 1'b1;
          state_nxt.countdown = '0;
          state_nxt.phase     = PH_IDLE;
        end
      endcase
    end
  end

  // result of this tick
  always_comb begin
    result               = '0;
    result.line_out      = state_nxt.driving ? state_nxt.out_level : 1'b1;
    result.drive_enable  = state_nxt.driving;
    result.send_accepted = is_idle && send_request;
    result.busy_res      = (state_nxt.phase != PH_IDLE);
    result.recv_valid    = timeout && (state_cur.phase == PH_RX_FINISH);
    result.recv_data     = result.recv_valid ? state_cur.shift_byte : 8'd0;
    result.start_error   = timeout && (state_cur.phase == PH_RX_START) && line_in;
    result.stop_error    = timeout && (state_cur.phase == PH_RX_STOP) && !line_in;
  end

endmodule

`default_nettype wire
